[rtl/lzd_pkg.sv]
package lzd_pkg;
  localparam int RingSize = 4096;
  localparam int RingAw = 12;
  localparam logic [11:0] RingStart = 12'hFEE;
  localparam int DefMaxWidth = 1024;
  localparam int MaxHeight = 4096;
  localparam int MaxRes = 6;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrFlag = 2'd1;
  localparam logic [1:0] ErrLit = 2'd2;
  localparam logic [1:0] ErrCopy = 2'd3;

  localparam logic [1:0] PhFlag = 2'd0;
  localparam logic [1:0] PhTok = 2'd1;
  localparam logic [1:0] PhCopy = 2'd2;

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_run;
    logic        image_done;
    logic [1:0]  error_code;
    logic [23:0] bytes_used;
  } pix_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       stream_end;
  } src_t;
endpackage

[rtl/lzd_if.sv]
interface lzd_src_if import lzd_pkg::*; ();
  logic valid;
  logic ready;
  src_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzd_pix_if import lzd_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/lzss_delta_image_decoder.sv]
// lzss image decoder with delta restoration
// src channel: one compressed byte per request plus a stream_end mark.
// pix channel: rgb pixels, error results, consumed byte count.
// cfg port: index 0 image_width, index 1 image_height; write only while idle.
// after reset a clearing pass sweeps the 4096 byte history ring, one entry
// a cycle, so no request is taken until the sweep has ended.
// a flag byte or the first byte of a copy token goes straight to the end
// of request state. each decoded byte passes ring read, line store read and
// write back; a literal skips the ring read. the end of request state first
// releases a pixel that still waits for its last-of-run mark, then a stream
// end error. the decoded byte loop through the ring and line store memories
// sets the rate; the next request waits for the output to drain.
// a completed pixel waits in a holding register until it is known whether
// more results follow, then moves to the output register; while the
// receiver stalls, decoding pauses when both are full. after image done or
// an error, further requests are taken and ignored.
module lzss_delta_image_decoder import lzd_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  lzd_src_if.sink     src,
  lzd_pix_if.source   pix
);
  localparam int LsDepth = 3 * MAX_WIDTH;
  localparam int LsAw = $clog2(LsDepth + 1);
  localparam int RwAw = 13;

  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SRd = 3'd2, SLs = 3'd3,
                         SWr = 3'd4, SOut = 3'd5, SErr = 3'd6;

  logic [7:0] ring_q [RingSize];
  logic [7:0] line_q [LsDepth];
  logic [7:0] ring_rd_q, line_rd_q;

  logic [2:0]  st_q;
  logic [11:0] clr_q, wpos_q, rpos_q;
  logic [15:0] flags_q;
  logic [1:0]  ph_q;
  logic [7:0]  held_q;
  logic [LsAw-1:0] rbi_q;
  logic [RwAw-1:0] row_q;
  logic [7:0]  p0_q, p1_q;
  logic [1:0]  pc_q;
  logic [23:0] cnt_q;
  logic        fin_q, defer_q, end_q, lit_q;
  logic [1:0]  derr_q;
  logic [4:0]  left_q;
  logic [2:0]  nres_q;
  logic [7:0]  val_q;
  logic [10:0] w_q;
  logic [12:0] h_q;
  pix_t        out_q;
  logic        ov_q;
  pix_t        hold_q;
  logic        hv_q;

  // effective geometry
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [LsAw+1:0] stride;
  always_comb begin
    w_eff = (w_q == 11'd0) ? 11'd1 : w_q;
    if (32'(w_eff) > MAX_WIDTH) w_eff = 11'(MAX_WIDTH);
    h_eff = (h_q == 13'd0) ? 13'd1 : h_q;
    if (32'(h_eff) > MaxHeight) h_eff = 13'(MaxHeight);
    stride = (LsAw+2)'(w_eff) * (LsAw+2)'(3);
  end

  // row wrap before the byte
  logic [LsAw-1:0] rbi_a;
  logic [RwAw-1:0] row_a;
  always_comb begin
    rbi_a = rbi_q;
    row_a = row_q;
    if ((LsAw+2)'(rbi_q) >= stride) begin
      rbi_a = '0;
      row_a = row_q + 1'b1;
    end
  end

  logic [LsAw-1:0] ls_addr;
  assign ls_addr = (row_a == '0) ? rbi_a - LsAw'(3) : rbi_a;

  // byte restore and position advance
  logic [7:0] add_v, rbyte;
  logic [LsAw-1:0] rbi_b;
  logic [RwAw-1:0] row_b;
  logic done_b, emit_b;
  always_comb begin
    add_v = (row_a != '0) ? line_rd_q : ((rbi_a >= LsAw'(3)) ? line_rd_q : 8'd0);
    rbyte = val_q + add_v;
    rbi_b = rbi_a + 1'b1;
    row_b = row_a;
    if ((LsAw+2)'(rbi_b) >= stride) begin
      rbi_b = '0;
      row_b = row_a + 1'b1;
    end
    done_b = 32'(row_b) >= 32'(h_eff);
    emit_b = (pc_q == 2'd2) || done_b;
  end

  logic [1:0] end_code;
  always_comb begin
    if (ph_q == PhFlag) end_code = ErrFlag;
    else if (ph_q == PhTok && flags_q[0]) end_code = ErrLit;
    else end_code = ErrCopy;
  end

  assign src.ready = (st_q == SIdle) && !ov_q;
  assign pix.valid = ov_q;
  assign pix.data = out_q;

  logic acc;
  assign acc = src.valid && src.ready;

  // result hand-off between holding and output registers
  logic slot_free, err_follow, wr_go, ov_set;
  pix_t hold_out;
  always_comb begin
    slot_free = !ov_q || pix.ready;
    err_follow = !fin_q && end_q && (nres_q < 3'(MaxRes));
    wr_go = (st_q == SWr) && !(emit_b && hv_q && !slot_free);
    hold_out = hold_q;
    hold_out.last_of_run = !err_follow;
    ov_set = 1'b0;
    if (st_q == SIdle) ov_set = acc && defer_q;
    else if (st_q == SWr) ov_set = wr_go && emit_b && hv_q;
    else if (st_q == SErr) ov_set = slot_free && (hv_q || err_follow);
  end

  // memories
  logic ring_we;
  logic [11:0] ring_wa;
  logic [7:0] ring_wd;
  always_comb begin
    ring_we = 1'b0;
    ring_wa = wpos_q;
    ring_wd = val_q;
    if (st_q == SClr) begin
      ring_we = 1'b1;
      ring_wa = clr_q;
      ring_wd = 8'd0;
    end else if (st_q == SWr) begin
      ring_we = wr_go;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[ring_wa] <= ring_wd;
    ring_rd_q <= ring_q[rpos_q];
    if (wr_go) line_q[rbi_a] <= rbyte;
    line_rd_q <= line_q[ls_addr];
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; clr_q <= '0; wpos_q <= RingStart; rpos_q <= '0;
      flags_q <= '0; ph_q <= PhFlag; held_q <= '0; rbi_q <= '0; row_q <= '0;
      pc_q <= '0; cnt_q <= '0; fin_q <= 1'b0; defer_q <= 1'b0; derr_q <= ErrNone;
      end_q <= 1'b0; lit_q <= 1'b0; left_q <= '0; nres_q <= '0; ov_q <= 1'b0;
      w_q <= 11'd1; h_q <= 13'd1; p0_q <= '0; p1_q <= '0; val_q <= '0;
      out_q <= '0; hold_q <= '0; hv_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgWidth) w_q <= cfg_data_i[10:0];
        else h_q <= cfg_data_i;
      end
      ov_q <= ov_set || (ov_q && !pix.ready);
      unique case (st_q)
        SClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == 12'hFFF) st_q <= SIdle;
        end
        SIdle: if (acc) begin
          nres_q <= '0;
          end_q <= src.data.stream_end;
          if (defer_q) begin
            defer_q <= 1'b0;
            out_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0, last_of_run: 1'b1,
                       image_done: 1'b0, error_code: derr_q, bytes_used: cnt_q};
          end else if (!fin_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (ph_q == PhFlag) begin
              flags_q <= {8'hFF, src.data.src_byte};
              ph_q <= PhTok;
              st_q <= SErr;
            end else if (ph_q == PhTok && flags_q[0]) begin
              val_q <= src.data.src_byte;
              lit_q <= 1'b1;
              left_q <= 5'd1;
              st_q <= SLs;
            end else if (ph_q == PhTok) begin
              held_q <= src.data.src_byte;
              ph_q <= PhCopy;
              st_q <= SErr;
            end else begin
              rpos_q <= {src.data.src_byte[7:4], held_q};
              left_q <= {1'b0, src.data.src_byte[3:0]} + 5'd3;
              lit_q <= 1'b0;
              st_q <= SRd;
            end
          end
        end
        SRd: begin
          rpos_q <= rpos_q + 1'b1;
          st_q <= SLs;
        end
        SLs: begin
          if (!lit_q) val_q <= ring_rd_q;
          st_q <= SWr;
        end
        SWr: begin
          if (wr_go) begin
            wpos_q <= wpos_q + 1'b1;
            rbi_q <= rbi_b;
            row_q <= row_b;
            left_q <= left_q - 1'b1;
            if (emit_b) begin
              if (hv_q) out_q <= hold_q;
              hold_q <= '{red: (pc_q == 2'd2) ? rbyte : 8'd0,
                          green: (pc_q == 2'd2) ? p1_q : ((pc_q == 2'd1) ? rbyte : 8'd0),
                          blue: (pc_q == 2'd0) ? rbyte : p0_q,
                          last_of_run: 1'b0, image_done: done_b,
                          error_code: ErrNone, bytes_used: cnt_q};
              hv_q <= 1'b1;
              nres_q <= nres_q + 1'b1;
              pc_q <= '0;
            end else begin
              if (pc_q == 2'd0) p0_q <= rbyte; else p1_q <= rbyte;
              pc_q <= pc_q + 1'b1;
            end
            if (done_b) fin_q <= 1'b1;
            if (done_b || left_q == 5'd1) begin
              flags_q <= {1'b0, flags_q[15:1]};
              ph_q <= flags_q[9] ? PhTok : PhFlag;
              st_q <= SErr;
            end else begin
              st_q <= SRd;
            end
          end
        end
        SOut: st_q <= SIdle;
        default: begin
          // end of request: release the held pixel, then the stream end error
          if (slot_free) begin
            if (hv_q) begin
              out_q <= hold_out;
              hv_q <= 1'b0;
            end else begin
              st_q <= SIdle;
              if (!fin_q && end_q) begin
                fin_q <= 1'b1;
                if (nres_q >= 3'(MaxRes)) begin
                  defer_q <= 1'b1;
                  derr_q <= end_code;
                end else begin
                  out_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0, last_of_run: 1'b1,
                             image_done: 1'b0, error_code: end_code, bytes_used: cnt_q};
                end
              end
            end
          end
        end
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src.ready |-> st_q == SIdle) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid && !pix.ready |=> pix.valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid && !pix.ready |=> $stable(pix.data)) else $error("result changed");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SIdle |-> !hv_q) else $error("held pixel in idle");
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q != 2'd3) else $error("pending count");
endmodule
